[hw/rtl/ple_pkg.sv]
// Package for the positional list engine: sizes, command and status codes,
// beat types and the ring address helper. No dependencies.
`default_nettype none

package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = CNT_W + 5;

   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_BACK  = 3'd1;
   localparam logic [2:0] OP_INS_AFTER = 3'd2;
   localparam logic [2:0] OP_REM_FRONT = 3'd3;
   localparam logic [2:0] OP_REM_BACK  = 3'd4;
   localparam logic [2:0] OP_REM_POS   = 3'd5;
   localparam logic [2:0] OP_CLEAR     = 3'd6;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [1:0]         status;
      logic [4:0]         element_count;
   } rsp_type;

   // Physical slot of list offset offs, the list starting at slot base.
   function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] offs);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (PTR_W + 1)'(CAPACITY)) begin
         sum = sum - (PTR_W + 1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/positional_list_engine.sv]
// Positional list engine: ordered list of signed 32-bit values kept in a
// ring buffer memory with a head pointer. Depends on ple_pkg.
//
//   beat      | direction | handshake           | payload
//   ----------+-----------+---------------------+-----------------------
//   command   | in        | req_valid/req_stall | req_data  (req_type)
//   result    | out       | rsp_valid/rsp_stall | rsp_data  (rsp_type)
//
// One command at a time. Front/back inserts, clear and rejected commands
// go straight to the output state; front/back removals first wait for one
// memory read. Positional insert and remove move one element at a time
// (read state, then write state) through the single-port-pair slot memory.
// Reset (synchronous) empties the list; slot contents are not cleared.
// A finished result waits in a holding state while an output beat is stalled.
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REM_WAIT,
      S_DN_RD,
      S_DN_WR,
      S_UP_RD,
      S_UP_WR,
      S_UP_PUT,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   req_type           cmd_ff, cmd_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic signed [31:0] rd_data_ff;

   logic signed [31:0] slots_mem [CAPACITY];

   logic [PTR_W-1:0]  rd_addr;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic signed [31:0] wr_data;

   logic [CMP_W-1:0]  cnt_x, pos_x, idx_x, cpos_x;
   logic [1:0]        chk_status;
   logic [PTR_W-1:0]  head_dec, head_inc;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cnt_x  = CMP_W'(count_ff);
   assign pos_x  = CMP_W'(req_data.position);
   assign idx_x  = CMP_W'(idx_ff);
   assign cpos_x = CMP_W'(cmd_ff.position);

   assign head_dec = (head_ff == '0) ? PTR_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;

   // Admission checks for the incoming command against the current count.
   always_comb begin
      chk_status = ST_DONE;
      unique case (req_data.opcode)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (cnt_x >= CMP_W'(CAPACITY)) chk_status = ST_FULL;
         end
         OP_INS_AFTER: begin
            priority if (cnt_x == '0) chk_status = ST_EMPTY;
            else if (pos_x < CMP_W'(1) || pos_x >= cnt_x) chk_status = ST_BADPOS;
            else if (cnt_x >= CMP_W'(CAPACITY)) chk_status = ST_FULL;
            else chk_status = ST_DONE;
         end
         OP_REM_FRONT, OP_REM_BACK: begin
            if (cnt_x == '0) chk_status = ST_EMPTY;
         end
         OP_REM_POS: begin
            priority if (cnt_x == '0) chk_status = ST_EMPTY;
            else if (pos_x < CMP_W'(2) || pos_x >= cnt_x) chk_status = ST_BADPOS;
            else chk_status = ST_DONE;
         end
         default: chk_status = ST_DONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = req_data.value;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in               = req_data;
               res_in.removed_value = '0;
               res_in.status        = chk_status;
               res_in.element_count = '0;
               state_in             = S_OUT;
               if (chk_status == ST_DONE) begin
                  unique case (req_data.opcode)
                     OP_INS_FRONT: begin
                        head_in  = head_dec;
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        count_in = count_ff + 1'b1;
                     end
                     OP_INS_BACK: begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_addr(head_ff, count_ff[PTR_W-1:0]);
                        count_in = count_ff + 1'b1;
                     end
                     OP_INS_AFTER: begin
                        idx_in   = count_ff[PTR_W-1:0];
                        state_in = S_UP_RD;
                     end
                     OP_REM_FRONT: begin
                        rd_addr  = head_ff;
                        state_in = S_REM_WAIT;
                     end
                     OP_REM_BACK: begin
                        rd_addr  = slot_addr(head_ff, PTR_W'(count_ff - 1'b1));
                        state_in = S_REM_WAIT;
                     end
                     OP_REM_POS: begin
                        idx_in   = PTR_W'(pos_x - CMP_W'(1));
                        rd_addr  = slot_addr(head_ff, PTR_W'(pos_x - CMP_W'(1)));
                        state_in = S_REM_WAIT;
                     end
                     OP_CLEAR: begin
                        count_in = '0;
                        head_in  = '0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_REM_WAIT: begin
            res_in.removed_value = rd_data_ff;
            unique case (cmd_ff.opcode)
               OP_REM_FRONT: begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
                  state_in = S_OUT;
               end
               OP_REM_POS: state_in = S_DN_RD;
               default: begin
                  count_in = count_ff - 1'b1;
                  state_in = S_OUT;
               end
            endcase
         end
         S_DN_RD: begin
            rd_addr  = slot_addr(head_ff, idx_ff + 1'b1);
            state_in = S_DN_WR;
         end
         S_DN_WR: begin
            // close the gap: move element idx+1 down to idx
            wr_en   = 1'b1;
            wr_addr = slot_addr(head_ff, idx_ff);
            wr_data = rd_data_ff;
            if (idx_x + CMP_W'(2) == cnt_x) begin
               count_in = count_ff - 1'b1;
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_DN_RD;
            end
         end
         S_UP_RD: begin
            rd_addr  = slot_addr(head_ff, idx_ff - 1'b1);
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            // open the gap: move element idx-1 up to idx
            wr_en   = 1'b1;
            wr_addr = slot_addr(head_ff, idx_ff);
            wr_data = rd_data_ff;
            idx_in  = idx_ff - 1'b1;
            if (idx_x - CMP_W'(1) == cpos_x) begin
               state_in = S_UP_PUT;
            end else begin
               state_in = S_UP_RD;
            end
         end
         S_UP_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = slot_addr(head_ff, idx_ff);
            wr_data  = cmd_ff.value;
            count_in = count_ff + 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.removed_value = res_ff.removed_value;
               rsp_data_in.status        = res_ff.status;
               rsp_data_in.element_count = cnt_x[4:0];
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slots_mem[rd_addr];
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for positional_list_engine: directed command table, then
// random list traffic scored against a behavioral list model kept inside the bench.
// Depends on ple_pkg and the positional_list_engine RTL.
`timescale 1ns / 100ps

module tb_top
   import ple_pkg::*;
();

   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int RANDOM_ITEMS   = 1360;
   localparam int HOLD_AT        = 100;
   localparam int HOLD_CYCLES    = 300;
   localparam int CALM_FROM      = 600;
   localparam int CALM_TO        = 800;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int OPENING_ROWS   = 26;

   typedef struct {
      req_type cmd;
      int      reps;
      bit      typed;
      rsp_type want;
   } cmd_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // expectation that rides along with the command on the wire
   bit      cmd_typed = 1'b0;
   rsp_type cmd_want = '0;

   logic signed [31:0] list_vals [CAPACITY];
   int                 list_len = 0;
   rsp_type            results_due [$];
   int                 cmds_taken = 0;
   int                 mismatches = 0;
   int                 quiet_cycles = 0;

   logic [2:0] insert_ops [3] = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_AFTER};
   logic [2:0] remove_ops [3] = '{OP_REM_FRONT, OP_REM_BACK, OP_REM_POS};

   cmd_row_type opening [OPENING_ROWS] = '{
      '{'{OP_REM_FRONT, 32'sd0, 5'd0}, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
      '{'{OP_REM_BACK, 32'sd0, 5'd0}, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
      '{'{OP_REM_POS, 32'sd0, 5'd2}, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
      '{'{OP_INS_AFTER, 32'sd5, 5'd1}, 1, 1'b1, '{32'sd0, ST_EMPTY, 5'd0}},
      '{'{OP_CLEAR, 32'sd0, 5'd0}, 1, 1'b1, '{32'sd0, ST_DONE, 5'd0}},
      '{'{OP_UNUSED, -32'sd1, 5'd31}, 1, 1'b1, '{32'sd0, ST_DONE, 5'd0}},
      '{'{OP_INS_FRONT, 32'sh7FFF_FFFF, 5'd0}, 1, 1'b1, '{32'sd0, ST_DONE, 5'd1}},
      '{'{OP_INS_BACK, 32'sh8000_0000, 5'd31}, 1, 1'b1, '{32'sd0, ST_DONE, 5'd2}},
      '{'{OP_INS_BACK, -32'sd1, 5'd0}, 1, 1'b1, '{32'sd0, ST_DONE, 5'd3}},
      '{'{OP_INS_AFTER, 32'sd1, 5'd0}, 1, 1'b1, '{32'sd0, ST_BADPOS, 5'd3}},
      '{'{OP_INS_AFTER, 32'sd1, 5'd3}, 1, 1'b1, '{32'sd0, ST_BADPOS, 5'd3}},
      '{'{OP_INS_AFTER, 32'sd1, 5'd31}, 1, 1'b1, '{32'sd0, ST_BADPOS, 5'd3}},
      '{'{OP_INS_AFTER, 32'sh1234_5678, 5'd1}, 1, 1'b0, '0},
      '{'{OP_REM_POS, 32'sd0, 5'd1}, 1, 1'b1, '{32'sd0, ST_BADPOS, 5'd4}},
      '{'{OP_REM_POS, 32'sd0, 5'd4}, 1, 1'b1, '{32'sd0, ST_BADPOS, 5'd4}},
      '{'{OP_REM_POS, 32'sd0, 5'd2}, 1, 1'b0, '0},
      '{'{OP_REM_FRONT, 32'sd0, 5'd0}, 1, 1'b1, '{32'sh7FFF_FFFF, ST_DONE, 5'd2}},
      '{'{OP_INS_AFTER, 32'sh0F0F_0F0F, 5'd1}, 1, 1'b0, '0},
      '{'{OP_INS_BACK, 32'sh5A5A_A5A5, 5'd0}, 13, 1'b0, '0},
      '{'{OP_INS_FRONT, 32'sd1, 5'd0}, 1, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
      '{'{OP_INS_BACK, 32'sd1, 5'd0}, 1, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
      '{'{OP_INS_AFTER, 32'sd1, 5'd5}, 1, 1'b1, '{32'sd0, ST_FULL, 5'd16}},
      '{'{OP_INS_AFTER, 32'sd1, 5'd16}, 1, 1'b1, '{32'sd0, ST_BADPOS, 5'd16}},
      '{'{OP_REM_POS, 32'sd0, 5'd15}, 1, 1'b0, '0},
      '{'{OP_REM_BACK, 32'sd0, 5'd0}, 1, 1'b0, '0},
      '{'{OP_CLEAR, 32'sd0, 5'd0}, 1, 1'b1, '{32'sd0, ST_DONE, 5'd0}}
   };

   positional_list_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- list model

   function automatic void list_open(input int idx, input logic signed [31:0] v);
      for (int k = list_len; k > idx; k--) list_vals[k] = list_vals[k-1];
      list_vals[idx] = v;
      list_len++;
   endfunction

   function automatic logic signed [31:0] list_take(input int idx);
      logic signed [31:0] v;
      v = list_vals[idx];
      for (int k = idx; k < list_len - 1; k++) list_vals[k] = list_vals[k+1];
      list_len--;
      return v;
   endfunction

   function automatic rsp_type list_apply(input req_type cmd);
      rsp_type r;
      int      pos;
      r = '0;
      r.status = ST_DONE;
      pos = int'(cmd.position);
      case (cmd.opcode)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (list_len >= CAPACITY) r.status = ST_FULL;
            else list_open((cmd.opcode == OP_INS_FRONT) ? 0 : list_len, cmd.value);
         end
         OP_INS_AFTER: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else if (pos < 1 || pos >= list_len) r.status = ST_BADPOS;
            else if (list_len >= CAPACITY) r.status = ST_FULL;
            else list_open(pos, cmd.value);
         end
         OP_REM_FRONT, OP_REM_BACK: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else r.removed_value = list_take((cmd.opcode == OP_REM_FRONT) ? 0 : list_len - 1);
         end
         OP_REM_POS: begin
            if (list_len == 0) r.status = ST_EMPTY;
            else if (pos < 2 || pos >= list_len) r.status = ST_BADPOS;
            else r.removed_value = list_take(pos - 1);
         end
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      r.element_count = 5'(list_len);
      return r;
   endfunction

   // ---------------------------------------------------------------- traffic

   function automatic bit take_break();
      if (cmds_taken >= CALM_FROM && cmds_taken < CALM_TO) return 1'b0;
      return $urandom_range(99) < 25;
   endfunction

   // Call at a falling edge; returns at the falling edge after the beat is taken.
   task automatic offer(input req_type cmd, input bit typed, input rsp_type want);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      cmd_typed <= typed;
      cmd_want  <= want;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   initial begin : cmd_side
      req_type cmd;
      int      roll;
      int      lo;
      bit      growing;
      growing = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i]) begin
         repeat (opening[i].reps) offer(opening[i].cmd, opening[i].typed, opening[i].want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (list_len == 0) growing = 1'b1;
         else if (list_len == CAPACITY) growing = 1'b0;
         else if ($urandom_range(99) < 5) growing = !growing;

         roll = $urandom_range(99);
         if (roll < 1) cmd.opcode = OP_CLEAR;
         else if (roll < 3) cmd.opcode = OP_UNUSED;
         else if ((roll < 68) == growing) cmd.opcode = insert_ops[$urandom_range(2)];
         else cmd.opcode = remove_ops[$urandom_range(2)];

         case ($urandom_range(9))
            0: cmd.value = 32'sh7FFF_FFFF;
            1: cmd.value = 32'sh8000_0000;
            2: cmd.value = 32'sd0;
            3: cmd.value = -32'sd1;
            default: cmd.value = $urandom();
         endcase

         // mostly legal positions; the rest spans the whole field
         lo = (cmd.opcode == OP_REM_POS) ? 2 : 1;
         if ($urandom_range(99) < 85 && list_len > lo)
            cmd.position = 5'($urandom_range(list_len - 1, lo));
         else
            cmd.position = 5'($urandom_range(31));

         offer(cmd, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin : rsp_side
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         // hold off long enough for the block to back up into its input
         if (!held && cmds_taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= take_break();
      end
   end

   // ---------------------------------------------------------------- scoring

   always @(posedge clock) begin : beat_check
      rsp_type predicted;
      rsp_type oldest;
      if (!reset) begin
         // score the result first so a command taken on this edge cannot match it
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result beat with no command outstanding");
               mismatches++;
            end else begin
               oldest = results_due.pop_front();
               if (rsp_data.removed_value !== oldest.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         oldest.removed_value, rsp_data.removed_value);
                  mismatches++;
               end
               if (rsp_data.status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.element_count !== oldest.element_count) begin
                  $error("element_count: expected %0d, got %0d",
                         oldest.element_count, rsp_data.element_count);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted = list_apply(req_data);
            results_due.push_back(cmd_typed ? cmd_want : predicted);
            cmds_taken++;
         end

         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

endmodule

[positional_list_engine.f]
hw/rtl/ple_pkg.sv
hw/rtl/positional_list_engine.sv
tb/tb_top.sv
